// File: rtl/mtep_pkg.sv
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Shared item types, status constants and parser phase codes.
// ----------------------------------------------------------------------------
package mtep_pkg;

	localparam int TICK_BITS_DEF = 32;

	localparam logic [7:0] DATA_MASK   = 8'h7F;
	localparam logic [7:0] STATUS_FLAG = 8'h80;
	localparam logic [7:0] META_BYTE   = 8'hFF;
	localparam logic [7:0] META_TEMPO  = 8'h51;
	localparam logic [7:0] META_EOT    = 8'h2F;
	localparam logic [7:0] SYSEX_BYTE  = 8'hF0;
	localparam logic [7:0] SYSEX_ESC   = 8'hF7;
	localparam logic [3:0] HI_NOTE_OFF = 4'h8;
	localparam logic [3:0] HI_NOTE_ON  = 4'h9;
	localparam logic [3:0] HI_POLY_AT  = 4'hA;
	localparam logic [3:0] HI_CTRL     = 4'hB;
	localparam logic [3:0] HI_PROG     = 4'hC;
	localparam logic [3:0] HI_CHAN_AT  = 4'hD;
	localparam logic [3:0] HI_PITCH    = 4'hE;

	localparam logic KIND_CHANNEL = 1'b0;
	localparam logic KIND_TEMPO   = 1'b1;

	typedef enum logic [9:0] {
		PH_DELTA     = 10'b00_0000_0001,
		PH_STATUS    = 10'b00_0000_0010,
		PH_DATA1     = 10'b00_0000_0100,
		PH_DATA2     = 10'b00_0000_1000,
		PH_META_TYPE = 10'b00_0001_0000,
		PH_META_LEN  = 10'b00_0010_0000,
		PH_SYSEX_LEN = 10'b00_0100_0000,
		PH_SKIP      = 10'b00_1000_0000,
		PH_TEMPO     = 10'b01_0000_0000,
		PH_DONE      = 10'b10_0000_0000
	} phase_t;

	typedef struct packed {
		logic [7:0] track_byte;
		logic       last_in_track;
	} in_item_t;

	typedef struct packed {
		logic        event_kind;
		logic [31:0] event_tick;
		logic [7:0]  status_byte;
		logic [7:0]  first_data;
		logic [7:0]  second_data;
		logic [23:0] tempo_us;
	} out_item_t;

	typedef struct packed {
		logic      valid;
		out_item_t item;
	} core_res_t;

endpackage

// File: rtl/mtep_core.sv
// ----------------------------------------------------------------------------
// MIDI track event parser core
// Track parse state and the one-byte step that decodes delta times, running
// status, meta and sysex events, and forms the result of a byte.
// ----------------------------------------------------------------------------
module mtep_core import mtep_pkg::*; #(
	parameter int TICK_BITS = TICK_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_item_t  item_s1,
	input  logic      notes_only,
	output core_res_t res
);

	phase_t               phase_q, n_phase;
	logic [TICK_BITS-1:0] abs_tick_q, n_abs_tick;
	logic [27:0]          vlq_value_q, n_vlq_value;
	logic [2:0]           vlq_count_q, n_vlq_count;
	logic [7:0]           running_status_q, n_running_status;
	logic [7:0]           current_status_q, n_current_status;
	logic [7:0]           held_data_q, n_held_data;
	logic [27:0]          skip_remaining_q, n_skip_remaining;
	logic [7:0]           meta_type_q, n_meta_type;
	logic [23:0]          tempo_accum_q, n_tempo_accum;
	logic [1:0]           tempo_count_q, n_tempo_count;

	logic [7:0]           b;
	logic [27:0]          vlq_new;
	logic [2:0]           vlq_cnt_new;
	logic                 vlq_done;
	logic [TICK_BITS:0]   tick_sum;
	logic [31:0]          tick_out;
	logic [27:0]          skip_dec;
	logic [23:0]          tempo_new;
	logic [1:0]           tempo_cnt_new;
	phase_t               skip_end_phase;

	function automatic logic is_two(input logic [7:0] st);
		return st[7:4] == HI_NOTE_OFF || st[7:4] == HI_NOTE_ON || st[7:4] == HI_POLY_AT
			|| st[7:4] == HI_CTRL || st[7:4] == HI_PITCH;
	endfunction

	function automatic logic is_one(input logic [7:0] st);
		return st[7:4] == HI_PROG || st[7:4] == HI_CHAN_AT;
	endfunction

	function automatic core_res_t emit_ch(input logic [7:0] st, input logic [7:0] d1,
			input logic [7:0] d2, input logic notes, input logic [31:0] tick);
		core_res_t r;
		r = '0;
		r.item.event_kind = KIND_CHANNEL;
		r.item.event_tick = tick;
		r.item.first_data = d1;
		if (!notes) begin
			r.valid = 1'b1;
			r.item.status_byte = st;
			r.item.second_data = d2;
		end else if (st[7:4] == HI_NOTE_ON && d2 != 8'h00) begin
			r.valid = 1'b1;
			r.item.status_byte = st;
			r.item.second_data = d2;
		end else if (st[7:4] == HI_NOTE_ON || st[7:4] == HI_NOTE_OFF) begin
			r.valid = 1'b1;
			r.item.status_byte = {HI_NOTE_OFF, st[3:0]};
		end
		return r;
	endfunction

	assign b             = item_s1.track_byte;
	assign vlq_new       = {vlq_value_q[20:0], b[6:0]};
	assign vlq_cnt_new   = vlq_count_q + 3'd1;
	assign vlq_done      = !b[7] || vlq_cnt_new >= 3'd4;
	assign tick_sum      = {1'b0, abs_tick_q} + (TICK_BITS+1)'(vlq_new);
	assign tick_out      = 32'(abs_tick_q);
	assign skip_dec      = (skip_remaining_q != 28'd0) ? skip_remaining_q - 28'd1 : 28'd0;
	assign tempo_new     = {tempo_accum_q[15:0], b};
	assign tempo_cnt_new = tempo_count_q + 2'd1;
	assign skip_end_phase = (meta_type_q == META_EOT) ? PH_DONE : PH_DELTA;

	always_comb begin
		n_phase          = phase_q;
		n_abs_tick       = abs_tick_q;
		n_vlq_value      = vlq_value_q;
		n_vlq_count      = vlq_count_q;
		n_running_status = running_status_q;
		n_current_status = current_status_q;
		n_held_data      = held_data_q;
		n_skip_remaining = skip_remaining_q;
		n_meta_type      = meta_type_q;
		n_tempo_accum    = tempo_accum_q;
		n_tempo_count    = tempo_count_q;
		res              = '0;
		unique case (phase_q)
			PH_DELTA: begin
				if (vlq_done) begin
					n_abs_tick  = tick_sum[TICK_BITS] ? '1 : tick_sum[TICK_BITS-1:0];
					n_vlq_value = '0;
					n_vlq_count = '0;
					n_phase     = PH_STATUS;
				end else begin
					n_vlq_value = vlq_new;
					n_vlq_count = vlq_cnt_new;
				end
			end
			PH_STATUS: begin
				priority if (b == META_BYTE) begin
					n_phase = PH_META_TYPE;
				end else if (b == SYSEX_BYTE || b == SYSEX_ESC) begin
					n_running_status = '0;
					n_meta_type      = '0;
					n_vlq_value      = '0;
					n_vlq_count      = '0;
					n_phase          = PH_SYSEX_LEN;
				end else if ((b & STATUS_FLAG) != 8'h00) begin
					if (is_one(b) || is_two(b)) begin
						n_running_status = b;
						n_current_status = b;
						n_phase          = PH_DATA1;
					end else begin
						n_meta_type      = '0;
						n_skip_remaining = 28'd1;
						n_phase          = PH_SKIP;
					end
				end else if (is_one(running_status_q)) begin
					res     = emit_ch(running_status_q, b, 8'h00, notes_only, tick_out);
					n_phase = PH_DELTA;
				end else if (is_two(running_status_q)) begin
					n_current_status = running_status_q;
					n_held_data      = b;
					n_phase          = PH_DATA2;
				end else begin
					n_phase = PH_DELTA;
				end
			end
			PH_DATA1: begin
				if (is_one(current_status_q)) begin
					res     = emit_ch(current_status_q, b, 8'h00, notes_only, tick_out);
					n_phase = PH_DELTA;
				end else begin
					n_held_data = b;
					n_phase     = PH_DATA2;
				end
			end
			PH_DATA2: begin
				res     = emit_ch(current_status_q, held_data_q, b, notes_only, tick_out);
				n_phase = PH_DELTA;
			end
			PH_META_TYPE: begin
				n_meta_type = b;
				n_vlq_value = '0;
				n_vlq_count = '0;
				n_phase     = PH_META_LEN;
			end
			PH_META_LEN, PH_SYSEX_LEN: begin
				if (vlq_done) begin
					n_vlq_value = '0;
					n_vlq_count = '0;
					if (phase_q == PH_META_LEN) begin
						n_running_status = '0;
					end
					if (phase_q == PH_META_LEN && meta_type_q == META_TEMPO
							&& vlq_new == 28'd3) begin
						n_tempo_accum = '0;
						n_tempo_count = '0;
						n_phase       = PH_TEMPO;
					end else if (vlq_new == 28'd0) begin
						n_phase = skip_end_phase;
					end else begin
						n_skip_remaining = vlq_new;
						n_phase          = PH_SKIP;
					end
				end else begin
					n_vlq_value = vlq_new;
					n_vlq_count = vlq_cnt_new;
				end
			end
			PH_SKIP: begin
				n_skip_remaining = skip_dec;
				if (skip_dec == 28'd0) begin
					n_phase = skip_end_phase;
				end
			end
			PH_TEMPO: begin
				if (tempo_cnt_new == 2'd3) begin
					n_tempo_accum = '0;
					n_tempo_count = '0;
					n_phase       = PH_DELTA;
					if (tempo_new != 24'd0 && !notes_only) begin
						res.valid           = 1'b1;
						res.item.event_kind = KIND_TEMPO;
						res.item.event_tick = tick_out;
						res.item.tempo_us   = tempo_new;
					end
				end else begin
					n_tempo_accum = tempo_new;
					n_tempo_count = tempo_cnt_new;
				end
			end
			PH_DONE: begin
				n_phase = PH_DONE;
			end
			default: begin
				n_phase = PH_DELTA;
			end
		endcase
		if (item_s1.last_in_track) begin
			n_phase          = PH_DELTA;
			n_abs_tick       = '0;
			n_vlq_value      = '0;
			n_vlq_count      = '0;
			n_running_status = '0;
			n_current_status = '0;
			n_held_data      = '0;
			n_skip_remaining = '0;
			n_meta_type      = '0;
			n_tempo_accum    = '0;
			n_tempo_count    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_DELTA;
			abs_tick_q       <= '0;
			vlq_value_q      <= '0;
			vlq_count_q      <= '0;
			running_status_q <= '0;
			current_status_q <= '0;
			held_data_q      <= '0;
			skip_remaining_q <= '0;
			meta_type_q      <= '0;
			tempo_accum_q    <= '0;
			tempo_count_q    <= '0;
		end else if (step) begin
			phase_q          <= n_phase;
			abs_tick_q       <= n_abs_tick;
			vlq_value_q      <= n_vlq_value;
			vlq_count_q      <= n_vlq_count;
			running_status_q <= n_running_status;
			current_status_q <= n_current_status;
			held_data_q      <= n_held_data;
			skip_remaining_q <= n_skip_remaining;
			meta_type_q      <= n_meta_type;
			tempo_accum_q    <= n_tempo_accum;
			tempo_count_q    <= n_tempo_count;
		end
	end

	a_vlq_short: assert property (@(posedge clk) disable iff (!arst_n)
		vlq_count_q <= 3'd3)
		else $error("length quantity ran past four bytes");

	a_notes_filter: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && notes_only |->
			res.item.event_kind == KIND_CHANNEL
			&& (res.item.status_byte[7:4] == HI_NOTE_ON
			|| res.item.status_byte[7:4] == HI_NOTE_OFF))
		else $error("non-note result in notes mode");

	a_track_clear: assert property (@(posedge clk) disable iff (!arst_n)
		step && item_s1.last_in_track |=> phase_q == PH_DELTA && abs_tick_q == '0)
		else $error("track state not cleared at track end");

endmodule

// File: rtl/midi_track_event_parser.sv
// ----------------------------------------------------------------------------
// MIDI track event parser
// Parses track chunk body bytes into timed channel messages and tempo changes.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  item      in         item_valid/item_stall  in_item_t (track byte, last flag)
//  result    out        result_valid/result_stall out_item_t
//  cfg       in         cfg_valid/cfg_ready    cfg_data (notes_only)
//
//  One byte a cycle while no result is stalled.
//  The byte register feeds the parse step, which writes the result register.
//  A stalled result holds the parse step; item_stall rises while it waits.
//  Reset clears all track state and the notes_only register.
// ----------------------------------------------------------------------------
module midi_track_event_parser import mtep_pkg::*; #(
	parameter int TICK_BITS = TICK_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_data
);

	in_item_t  item_s1;
	logic      valid_s1;
	logic      step;
	logic      notes_only_q;
	logic      out_valid_q;
	out_item_t out_q;
	core_res_t res;

	assign step       = valid_s1 && (!out_valid_q || !result_stall);
	assign item_stall = valid_s1 && !step;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			notes_only_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			notes_only_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	mtep_core #(
		.TICK_BITS(TICK_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item_s1   (item_s1),
		.notes_only(notes_only_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= res.valid;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			out_q <= res.item;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && out_valid_q && result_stall)
		else $error("input stalled without a held result");

	a_tempo_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.event_kind == KIND_TEMPO |->
			out_q.status_byte == 8'h00 && out_q.first_data == 8'h00
			&& out_q.second_data == 8'h00 && out_q.tempo_us != 24'd0)
		else $error("malformed tempo result");

	a_channel_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.event_kind == KIND_CHANNEL |-> out_q.tempo_us == 24'd0)
		else $error("channel result carries a tempo");

endmodule

// File: verif/track_event_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI track event checker
// Watches the byte, result and register channels of the track parser, works
// out any expected event for every accepted byte and compares each accepted
// result field by field with the oldest expected event.
// ----------------------------------------------------------------------------
module track_event_check import mtep_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	input  logic      item_stall,
	input  in_item_t  item,
	input  logic      result_valid,
	input  logic      result_stall,
	input  out_item_t result,
	input  logic      cfg_valid,
	input  logic      cfg_ready,
	input  logic      cfg_data,
	output int        pending_events,
	output int        mismatch_count
);

	localparam int MAX_REPORTS = 200;

	phase_t      parse_ph;
	logic [31:0] tick_acc;
	logic [27:0] vlq_acc;
	logic [2:0]  vlq_n;
	logic [7:0]  run_status;
	logic [7:0]  cur_status;
	logic [7:0]  held_byte;
	logic [27:0] skip_left;
	logic [7:0]  meta_kind;
	logic [23:0] tempo_acc;
	logic [1:0]  tempo_n;
	logic        notes_mode;

	out_item_t   expected_events[$];
	logic        event_due;
	out_item_t   predicted;
	out_item_t   oldest;

	function automatic logic has_one_data(input logic [7:0] st);
		return st[7:4] == HI_PROG || st[7:4] == HI_CHAN_AT;
	endfunction

	function automatic logic has_two_data(input logic [7:0] st);
		return st[7:4] == HI_NOTE_OFF || st[7:4] == HI_NOTE_ON || st[7:4] == HI_POLY_AT ||
			st[7:4] == HI_CTRL || st[7:4] == HI_PITCH;
	endfunction

	function automatic logic feed_vlq(input logic [7:0] b);
		vlq_acc = {vlq_acc[20:0], b[6:0]};
		vlq_n = vlq_n + 3'd1;
		return !b[7] || vlq_n >= 3'd4;
	endfunction

	function automatic void finish_skip();
		parse_ph = (meta_kind == META_EOT) ? PH_DONE : PH_DELTA;
	endfunction

	function automatic void begin_skip(input logic [27:0] n);
		if (n == '0) begin
			finish_skip();
		end else begin
			skip_left = n;
			parse_ph = PH_SKIP;
		end
	endfunction

	function automatic void clear_track_state();
		parse_ph = PH_DELTA;
		tick_acc = '0;
		vlq_acc = '0;
		vlq_n = '0;
		run_status = '0;
		cur_status = '0;
		held_byte = '0;
		skip_left = '0;
		meta_kind = '0;
		tempo_acc = '0;
		tempo_n = '0;
	endfunction

	function automatic void emit_channel(input logic [7:0] st, input logic [7:0] d1,
		input logic [7:0] d2);
		parse_ph = PH_DELTA;
		predicted = '0;
		predicted.event_kind = KIND_CHANNEL;
		predicted.event_tick = tick_acc;
		predicted.first_data = d1;
		if (!notes_mode) begin
			event_due = 1'b1;
			predicted.status_byte = st;
			predicted.second_data = d2;
		end else if (st[7:4] == HI_NOTE_ON && d2 != 8'h00) begin
			event_due = 1'b1;
			predicted.status_byte = st;
			predicted.second_data = d2;
		end else if (st[7:4] == HI_NOTE_OFF || st[7:4] == HI_NOTE_ON) begin
			event_due = 1'b1;
			predicted.status_byte = {HI_NOTE_OFF, st[3:0]};
		end
	endfunction

	function automatic void parse_track_byte(input logic [7:0] b);
		logic [32:0] sum;
		logic [27:0] n;
		logic [23:0] tv;
		event_due = 1'b0;
		case (parse_ph)
			PH_DELTA: begin
				if (feed_vlq(b)) begin
					sum = {1'b0, tick_acc} + {5'b0, vlq_acc};
					tick_acc = sum[32] ? '1 : sum[31:0];
					vlq_acc = '0;
					vlq_n = '0;
					parse_ph = PH_STATUS;
				end
			end
			PH_STATUS: begin
				if (b == META_BYTE) begin
					parse_ph = PH_META_TYPE;
				end else if (b == SYSEX_BYTE || b == SYSEX_ESC) begin
					run_status = '0;
					meta_kind = '0;
					vlq_acc = '0;
					vlq_n = '0;
					parse_ph = PH_SYSEX_LEN;
				end else if (b[7]) begin
					if (has_one_data(b) || has_two_data(b)) begin
						run_status = b;
						cur_status = b;
						parse_ph = PH_DATA1;
					end else begin
						meta_kind = '0;
						begin_skip(28'd1);
					end
				end else if (has_one_data(run_status)) begin
					emit_channel(run_status, b, 8'h00);
				end else if (has_two_data(run_status)) begin
					cur_status = run_status;
					held_byte = b;
					parse_ph = PH_DATA2;
				end else begin
					parse_ph = PH_DELTA;
				end
			end
			PH_DATA1: begin
				if (has_one_data(cur_status)) begin
					emit_channel(cur_status, b, 8'h00);
				end else begin
					held_byte = b;
					parse_ph = PH_DATA2;
				end
			end
			PH_DATA2: emit_channel(cur_status, held_byte, b);
			PH_META_TYPE: begin
				meta_kind = b;
				vlq_acc = '0;
				vlq_n = '0;
				parse_ph = PH_META_LEN;
			end
			PH_META_LEN: begin
				if (feed_vlq(b)) begin
					n = vlq_acc;
					vlq_acc = '0;
					vlq_n = '0;
					run_status = '0;
					if (meta_kind == META_TEMPO && n == 28'd3) begin
						tempo_acc = '0;
						tempo_n = '0;
						parse_ph = PH_TEMPO;
					end else begin
						begin_skip(n);
					end
				end
			end
			PH_SYSEX_LEN: begin
				if (feed_vlq(b)) begin
					n = vlq_acc;
					vlq_acc = '0;
					vlq_n = '0;
					begin_skip(n);
				end
			end
			PH_SKIP: begin
				if (skip_left != '0)
					skip_left = skip_left - 28'd1;
				if (skip_left == '0)
					finish_skip();
			end
			PH_TEMPO: begin
				tempo_acc = {tempo_acc[15:0], b};
				tempo_n = tempo_n + 2'd1;
				if (tempo_n == 2'd3) begin
					tv = tempo_acc;
					tempo_acc = '0;
					tempo_n = '0;
					parse_ph = PH_DELTA;
					if (tv != '0 && !notes_mode) begin
						event_due = 1'b1;
						predicted = '0;
						predicted.event_kind = KIND_TEMPO;
						predicted.event_tick = tick_acc;
						predicted.tempo_us = tv;
					end
				end
			end
			PH_DONE: ;
			default: parse_ph = PH_DELTA;
		endcase
	endfunction

	task automatic queue_event(input out_item_t ev);
		expected_events.insert(expected_events.size(), ev);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] seen,
		input logic [31:0] wanted);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t: %s: got %0h, want %0h", $time, what, seen, wanted);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_track_state();
			notes_mode = 1'b0;
			expected_events.delete();
			mismatch_count = 0;
			pending_events = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				notes_mode = cfg_data;
			if (item_valid && !item_stall) begin
				parse_track_byte(item.track_byte);
				if (item.last_in_track)
					clear_track_state();
				if (event_due)
					queue_event(predicted);
			end
			if (result_valid && !result_stall) begin
				if (expected_events.size() == 0) begin
					report_mismatch("unpredicted result, tick", result.event_tick, '0);
				end else begin
					oldest = expected_events.pop_front();
					if (result.event_kind !== oldest.event_kind)
						report_mismatch("event_kind", 32'(result.event_kind),
							32'(oldest.event_kind));
					if (result.event_tick !== oldest.event_tick)
						report_mismatch("event_tick", result.event_tick, oldest.event_tick);
					if (result.status_byte !== oldest.status_byte)
						report_mismatch("status_byte", 32'(result.status_byte),
							32'(oldest.status_byte));
					if (result.first_data !== oldest.first_data)
						report_mismatch("first_data", 32'(result.first_data),
							32'(oldest.first_data));
					if (result.second_data !== oldest.second_data)
						report_mismatch("second_data", 32'(result.second_data),
							32'(oldest.second_data));
					if (result.tempo_us !== oldest.tempo_us)
						report_mismatch("tempo_us", 32'(result.tempo_us),
							32'(oldest.tempo_us));
				end
			end
			pending_events = expected_events.size();
		end
	end

endmodule

// File: verif/midi_track_event_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI track event parser testbench
// Feeds a short directed track and then random tracks built mostly from
// well-formed events, under both settings of the notes-only register and
// three mixes of sender and receiver idling; the checker beside the parser
// predicts and compares every result.
// ----------------------------------------------------------------------------
module midi_track_event_parser_test;
	import mtep_pkg::*;

	localparam int CLK_PERIOD     = 8;
	localparam int PHASE_ITEMS    = 235;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 5000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_stall;
	in_item_t  item = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_item_t result;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic      cfg_data = 1'b0;

	int        pending_events;
	int        mismatch_count;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;
	int        quiet_cycles = 0;
	logic [7:0] track_q[$];

	midi_track_event_parser dut (
		.clk, .arst_n, .item_valid, .item_stall, .item, .result_valid, .result_stall,
		.result, .cfg_valid, .cfg_ready, .cfg_data
	);

	track_event_check event_check (
		.clk, .arst_n, .item_valid, .item_stall, .item, .result_valid, .result_stall,
		.result, .cfg_valid, .cfg_ready, .cfg_data, .pending_events, .mismatch_count
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(negedge clk)
		result_stall = ($urandom_range(99) < recv_idle_pct);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("SCOREBOARD MISMATCH");
					$finish;
				end
			end
		end
	end

	task automatic write_notes_mode(input logic v);
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_track();
		for (int i = 0; i < track_q.size(); i++) begin
			while ($urandom_range(99) < send_idle_pct) begin
				item_valid = 1'b0;
				@(negedge clk);
			end
			item_valid = 1'b1;
			item.track_byte = track_q[i];
			item.last_in_track = (i == track_q.size() - 1);
			do @(posedge clk); while (item_stall);
			@(negedge clk);
			item_valid = 1'b0;
		end
		track_q.delete();
	endtask

	task automatic drain();
		while (pending_events != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic add_byte(input logic [7:0] v);
		track_q.insert(track_q.size(), v);
	endtask

	task automatic push_vlq(input logic [27:0] v);
		int n;
		n = 1;
		if (v >= 28'h80)
			n = 2;
		if (v >= 28'h4000)
			n = 3;
		if (v >= 28'h200000)
			n = 4;
		for (int i = n - 1; i >= 0; i--)
			add_byte({i != 0, v[7 * i +: 7]});
	endtask

	task automatic push_channel_data(input logic [7:0] st, input logic explicit_status);
		logic [7:0] d;
		d = (explicit_status && $urandom_range(9) == 0) ? 8'($urandom_range(255)) :
			8'($urandom_range(127));
		add_byte(d);
		if (!(st[7:4] == HI_PROG || st[7:4] == HI_CHAN_AT)) begin
			d = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(127));
			if (st[7:4] == HI_NOTE_ON && $urandom_range(3) == 0)
				d = 8'h00;
			add_byte(d);
		end
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct, input logic notes);
		int         sent;
		int         n_events;
		int         sat_pct;
		int         r;
		int         len;
		logic [3:0] hi;
		logic [7:0] st;
		logic [7:0] run_st;
		logic [7:0] b;
		logic [23:0] tempo;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		write_notes_mode(notes);
		sent = 0;
		while (sent < PHASE_ITEMS) begin
			run_st = '0;
			sat_pct = ($urandom_range(9) == 0) ? 80 : 0;
			n_events = (sat_pct != 0) ? 24 : $urandom_range(3, 16);
			repeat (n_events) begin
				r = $urandom_range(99);
				if (r < sat_pct) begin
					push_vlq(28'h0FFFFFFF);
				end else if (r < sat_pct + 3) begin
					repeat (4) add_byte(8'h80 | 8'($urandom_range(255)));
				end else if (r < 60) begin
					push_vlq('0);
				end else if (r < 85) begin
					push_vlq(28'($urandom_range(127)));
				end else if (r < 95) begin
					push_vlq(28'($urandom_range(16383)));
				end else begin
					push_vlq(28'($urandom_range(28'h0FFFFFFF)));
				end
				r = $urandom_range(99);
				if (r < 45 || (r < 65 && run_st == '0)) begin
					hi = ($urandom_range(2) == 0) ? HI_NOTE_ON : 4'($urandom_range(8, 14));
					st = {hi, 4'($urandom_range(15))};
					add_byte(st);
					run_st = st;
					push_channel_data(st, 1'b1);
				end else if (r < 65) begin
					push_channel_data(run_st, 1'b0);
				end else if (r < 73) begin
					add_byte(META_BYTE);
					add_byte(META_TEMPO);
					add_byte(8'h03);
					tempo = 24'($urandom);
					if ($urandom_range(4) == 0)
						tempo = '0;
					else if ($urandom_range(9) == 0)
						tempo = '1;
					add_byte(tempo[23:16]);
					add_byte(tempo[15:8]);
					add_byte(tempo[7:0]);
					run_st = '0;
				end else if (r < 78) begin
					len = $urandom_range(4);
					if (len >= 3)
						len++;
					add_byte(META_BYTE);
					add_byte(META_TEMPO);
					push_vlq(28'(len));
					repeat (len) add_byte(8'($urandom_range(255)));
					run_st = '0;
				end else if (r < 86) begin
					do b = 8'($urandom_range(255)); while (b == META_TEMPO || b == META_EOT);
					len = $urandom_range(4);
					add_byte(META_BYTE);
					add_byte(b);
					push_vlq(28'(len));
					repeat (len) add_byte(8'($urandom_range(255)));
					run_st = '0;
				end else if (r < 92) begin
					len = ($urandom_range(9) == 0) ? $urandom_range(128, 200) : $urandom_range(4);
					add_byte($urandom_range(1) ? SYSEX_BYTE : SYSEX_ESC);
					push_vlq(28'(len));
					repeat (len) add_byte(8'($urandom_range(255)));
					run_st = '0;
				end else if (r < 96) begin
					do b = 8'($urandom_range(8'hF1, 8'hFE)); while (b == SYSEX_ESC);
					add_byte(b);
					add_byte(8'($urandom_range(255)));
				end else if (r < 98) begin
					add_byte(8'($urandom_range(127)));
				end else begin
					add_byte(8'($urandom_range(255)));
				end
			end
			r = $urandom_range(99);
			if (r < 65) begin
				add_byte(8'h00);
				add_byte(META_BYTE);
				add_byte(META_EOT);
				add_byte(8'h00);
				repeat ($urandom_range(3)) add_byte(8'($urandom_range(255)));
			end else if (r < 80) begin
				add_byte(8'h00);
				add_byte({HI_NOTE_ON, 4'($urandom_range(15))});
				add_byte(8'($urandom_range(127)));
			end
			sent += track_q.size();
			send_track();
		end
		drain();
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		write_notes_mode(1'b0);
		track_q = '{
			8'h00, {HI_NOTE_ON, 4'h0}, 8'h3C, 8'h7F,
			8'h00, 8'h3C, 8'h00,
			8'h81, 8'h80, 8'h80, 8'hFF, {HI_PROG, 4'h5}, 8'h20,
			8'h00, META_BYTE, META_TEMPO, 8'h03, 8'h07, 8'hA1, 8'h20,
			8'h00, 8'h45,
			8'h00, SYSEX_BYTE | 8'h03, 8'h01,
			8'h00, META_BYTE, META_EOT, 8'h00,
			8'h55
		};
		send_track();
		drain();
		run_phase(35, 48, 1'b1);
		run_phase(35, 48, 1'b0);
		run_phase(48, 35, 1'b1);
		run_phase(48, 35, 1'b0);
		run_phase(0, 0, 1'b1);
		run_phase(0, 0, 1'b0);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
